/* design/brfpe_pkg.sv */
// Shared types, constants and pulse lookup for the blind remote frame pulse encoder.
package brfpe_pkg;

	localparam int UsW = 12;
	localparam int FrameBits = 40;
	localparam int IdxW = 6;
	localparam int PreambleLen = 5;
	localparam logic [IdxW-1:0] LastIdx = 6'd45;

	typedef logic [UsW-1:0] us_t;
	typedef logic [IdxW-1:0] idx_t;
	typedef logic [FrameBits-1:0] frame_t;

	typedef enum logic [1:0] {
		KIND_UP   = 2'd0,
		KIND_DOWN = 2'd1,
		KIND_STOP = 2'd2
	} kind_t;

	localparam logic [7:0] CmdUp   = 8'hC0;
	localparam logic [7:0] CmdDown = 8'h10;
	localparam logic [7:0] CmdStop = 8'h50;
	localparam logic [7:0] UnitMask = 8'h0F;
	localparam logic [7:0] FixedByte = 8'd192;

	localparam us_t BitLong  = 12'd670;
	localparam us_t BitShort = 12'd270;
	localparam us_t TrailHi  = 12'd630;
	localparam us_t TrailLo  = 12'd50;

	typedef struct packed {
		us_t  hi;
		us_t  lo;
		logic last;
	} pulse_t;

	function automatic pulse_t pulse_lookup(input idx_t idx, input frame_t frame);
		pulse_t p;
		idx_t   bidx;
		p    = '{hi: TrailHi, lo: TrailLo, last: 1'b0};
		bidx = idx - idx_t'(PreambleLen);
		case (idx)
			6'd0: p = '{hi: 12'd2450, lo: 12'd10, last: 1'b0};
			6'd1: p = '{hi: 12'd2450, lo: 12'd2450, last: 1'b0};
			6'd2: p = '{hi: 12'd630, lo: 12'd10, last: 1'b0};
			6'd3: p = '{hi: 12'd630, lo: 12'd10, last: 1'b0};
			6'd4: p = '{hi: 12'd350, lo: 12'd350, last: 1'b0};
			default: begin
				if (idx >= LastIdx) begin
					p = '{hi: TrailHi, lo: TrailLo, last: 1'b1};
				end else if (frame[bidx]) begin
					p = '{hi: BitLong, lo: BitShort, last: 1'b0};
				end else begin
					p = '{hi: BitShort, lo: BitLong, last: 1'b0};
				end
			end
		endcase
		return p;
	endfunction

endpackage

/* design/brfpe_frame.sv */
// Builds the five frame bytes (with checksum) from one command.
module brfpe_frame (
	input  logic [1:0]           kind,
	input  logic [15:0]          house,
	input  logic [3:0]           unit,
	output brfpe_pkg::frame_t    frame
);

	logic [7:0] b0, b1, b2, b3, b4, cmd;
	logic [7:0] sum;

	always_comb begin
		unique case (kind)
			brfpe_pkg::KIND_UP:   cmd = brfpe_pkg::CmdUp;
			brfpe_pkg::KIND_DOWN: cmd = brfpe_pkg::CmdDown;
			brfpe_pkg::KIND_STOP: cmd = brfpe_pkg::CmdStop;
			default:              cmd = 8'h00;
		endcase
		b0  = house[15:8];
		b1  = house[7:0];
		b2  = ({4'h0, unit} & brfpe_pkg::UnitMask) | cmd;
		b3  = brfpe_pkg::FixedByte;
		sum = b0 + b1 + b2 + b3;
		b4  = 8'd1 - sum;
	end

	assign frame = {b4, b3, b2, b1, b0};

endmodule

/* design/brfpe_seq.sv */
// Frame register, pulse index counter and output result register.
module brfpe_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 load,
	input  brfpe_pkg::frame_t    frame,
	output logic                 busy_done,
	output logic                 active,
	input  logic                 out_ready,
	output logic                 out_valid,
	output brfpe_pkg::pulse_t    out_pulse
);

	brfpe_pkg::frame_t frame_q;
	brfpe_pkg::idx_t   idx_q;
	logic              active_q;
	logic              valid_q;
	brfpe_pkg::pulse_t pulse_q;
	logic              adv;

	assign adv       = active_q && (!valid_q || out_ready);
	assign busy_done = adv && (idx_q == brfpe_pkg::LastIdx);
	assign active    = active_q;
	assign out_valid = valid_q;
	assign out_pulse = pulse_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			active_q <= 1'b1;
			idx_q    <= '0;
		end else if (busy_done) begin
			active_q <= 1'b0;
			idx_q    <= '0;
		end else if (adv) begin
			idx_q <= idx_q + 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			frame_q <= frame;
		end
		if (adv) begin
			pulse_q <= brfpe_pkg::pulse_lookup(idx_q, frame_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> (!active_q || busy_done))
		else $error("load while frame in progress");

	a_load_start: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (active_q && idx_q == '0))
		else $error("load did not start frame");

	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (idx_q <= brfpe_pkg::LastIdx))
		else $error("pulse index out of range");

	a_last_tag: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (pulse_q.last == ($past(idx_q) == brfpe_pkg::LastIdx)))
		else $error("last flag mismatch");

	a_idle_idx: assert property (@(posedge clk) disable iff (!arst_n)
		!active_q |-> (idx_q == '0))
		else $error("index not cleared when idle");

endmodule

/* design/blind_remote_frame_pulse_encoder_core.sv */
// Top level of the blind remote frame pulse encoder.
//  channel | dir | fields (tdata low bit up)           | notes
//  s_*     | in  | kind[1:0] house[17:2] unit[21:18]    | one command per transaction
//  m_*     | out | high_us[11:0] low_us[23:12], tlast   | 46 pulse transactions per command
// Each command yields 46 results, one per cycle while m_tready is high.
// A pulse index counter over the registered frame steps through the 46 pulses.
// The next command is taken in the cycle the trailer enters the output register.
// Output stalls hold the counter; arst_n clears control state only.
module blind_remote_frame_pulse_encoder_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,   // kind[1:0], house[17:2], unit[21:18], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // high_us[11:0], low_us[23:12]
	output logic        m_tlast
);

	brfpe_pkg::frame_t frame;
	brfpe_pkg::pulse_t pulse;
	logic              done, active, load;

	assign s_tready = !active || done;
	assign load     = s_tvalid && s_tready;

	brfpe_frame u_frame (
		.kind  (s_tdata[1:0]),
		.house (s_tdata[17:2]),
		.unit  (s_tdata[21:18]),
		.frame (frame)
	);

	brfpe_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.frame     (frame),
		.busy_done (done),
		.active    (active),
		.out_ready (m_tready),
		.out_valid (m_tvalid),
		.out_pulse (pulse)
	);

	assign m_tdata = {pulse.lo, pulse.hi};
	assign m_tlast = pulse.last;

endmodule
